FILE: hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the range maximum query engine.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int WORD_SIZE_DEF    = 64;
    localparam int BLOCK_LEVELS_DEF = 6;

    localparam int VALUE_W = 64;
    localparam int LEFT_W  = 12;
    localparam int RIGHT_W = 13;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef struct packed {
        func_t                      func;
        logic signed [VALUE_W-1:0]  element_value;
        logic                       last_element;
        logic [LEFT_W-1:0]          range_left;
        logic [RIGHT_W-1:0]         range_right;
        logic                       bad_order;
    } item_t;

endpackage

FILE: hw/rtl/rmq_ram.sv
// ----------------------------------------------------------------------------
// rmq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Input side: takes items, tags ill-ordered ranges and queues them for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  rmq_pkg::func_t                     func,
    input  logic signed [rmq_pkg::VALUE_W-1:0] element_value,
    input  logic                               last_element,
    input  logic [rmq_pkg::LEFT_W-1:0]         range_left,
    input  logic [rmq_pkg::RIGHT_W-1:0]        range_right,
    output logic                               head_valid,
    output rmq_pkg::item_t                     head_item,
    input  logic                               take
);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    rmq_pkg::item_t       ent_reg [QDEPTH];
    rmq_pkg::item_t       new_item;
    logic [QAW-1:0]       wptr_reg, wptr_next;
    logic [QAW-1:0]       rptr_reg, rptr_next;
    logic [QAW:0]         cnt_reg, cnt_next;
    logic                 wr, rd;

    assign full       = (cnt_reg == (QAW+1)'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = ent_reg[rptr_reg];
    assign wr         = push && !full;
    assign rd         = take && head_valid;

    always_comb
    begin
        new_item.func          = func;
        new_item.element_value = element_value;
        new_item.last_element  = last_element;
        new_item.range_left    = range_left;
        new_item.range_right   = range_right;
        new_item.bad_order     = ({1'b0, range_left} >= range_right);
        wptr_next = wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (QAW+1)'(wr) - (QAW+1)'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            ent_reg[wptr_reg] <= new_item;
        end
    end

endmodule

FILE: hw/rtl/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// Execution side: element load with in-word monotonic stack, word-maximum
// table build, query sequencing and the result register.
// ----------------------------------------------------------------------------
module rmq_back #(
    parameter int MAX_ELEMENTS = rmq_pkg::MAX_ELEMENTS_DEF,
    parameter int WORD_SIZE    = rmq_pkg::WORD_SIZE_DEF,
    parameter int BLOCK_LEVELS = rmq_pkg::BLOCK_LEVELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  rmq_pkg::item_t                     head_item,
    output logic                               take,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [rmq_pkg::VALUE_W-1:0] max_value,
    output logic                               range_error
);

    localparam int VW     = rmq_pkg::VALUE_W;
    localparam int AW     = $clog2(MAX_ELEMENTS);
    localparam int LEN_W  = AW + 1;
    localparam int LW     = $clog2(WORD_SIZE);
    localparam int DW     = LW + 1;
    localparam int NBLK   = MAX_ELEMENTS / WORD_SIZE;
    localparam int BW     = (NBLK > 1) ? $clog2(NBLK) : 1;
    localparam int TDEPTH = BLOCK_LEVELS * NBLK;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int KW     = (BLOCK_LEVELS > 1) ? $clog2(BLOCK_LEVELS) : 1;
    localparam int IW     = $clog2(BLOCK_LEVELS + 1);
    localparam int BIX_W  = rmq_pkg::RIGHT_W - LW + 1;
    localparam int SW     = BIX_W + 2;
    localparam int LX_W   = rmq_pkg::RIGHT_W + 1;
    localparam int STK_W  = LW + VW;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_POP     = 13'b0000000000010,
        S_PUSH    = 13'b0000000000100,
        S_BLD_CHK = 13'b0000000001000,
        S_BLD_RA  = 13'b0000000010000,
        S_BLD_RB  = 13'b0000000100000,
        S_BLD_W   = 13'b0000001000000,
        S_Q_NEXT  = 13'b0000010000000,
        S_Q_TRD   = 13'b0000100000000,
        S_Q_TWT   = 13'b0001000000000,
        S_W_MRD   = 13'b0010000000000,
        S_W_MWT   = 13'b0100000000000,
        S_W_EWT   = 13'b1000000000000
    } state_t;

    function automatic logic [TAW-1:0] tab_addr(input int lvl, input int idx);
        return TAW'(lvl * NBLK + idx);
    endfunction

    function automatic logic signed [VW-1:0] smax(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
        return (a <= b) ? b : a;
    endfunction

    function automatic logic [LW-1:0] ctz(input logic [WORD_SIZE-1:0] m);
        logic [LW-1:0] n;
        n = LW'(WORD_SIZE - 1);
        for (int i = WORD_SIZE - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                n = LW'(i);
            end
        end
        return n;
    endfunction

    function automatic int flog2(input logic [BIX_W-1:0] x);
        int n;
        n = 0;
        for (int i = 1; i < BIX_W; i++)
        begin
            if (x[i])
            begin
                n = i;
            end
        end
        return n;
    endfunction

    // control state
    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   done_reg, done_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic [IW-1:0]          lvl_reg, lvl_next;
    logic [BW:0]            bj_reg, bj_next;
    logic                   blk_reg, blk_next;
    logic                   sega_reg, sega_next;
    logic                   segb_reg, segb_next;
    logic                   single_reg, single_next;
    logic                   fin_reg, fin_next;
    logic                   out_valid_reg, out_valid_next;

    // payload
    logic [WORD_SIZE-1:0]   rmask_reg, rmask_next;
    logic [LW-1:0]          top_idx_reg, top_idx_next;
    logic signed [VW-1:0]   top_val_reg, top_val_next;
    logic signed [VW-1:0]   bot_val_reg, bot_val_next;
    logic signed [VW-1:0]   val_reg, val_next;
    logic                   last_reg, last_next;
    logic signed [VW-1:0]   tmp_reg, tmp_next;
    logic [rmq_pkg::LEFT_W-1:0]  l_reg, l_next;
    logic [rmq_pkg::RIGHT_W-1:0] r_reg, r_next;
    logic [BIX_W-1:0]       lb_reg, lb_next;
    logic [BIX_W-1:0]       rb_reg, rb_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [BIX_W-1:0]       pos_reg, pos_next;
    logic [rmq_pkg::LEFT_W-1:0]  seg_l_reg, seg_l_next;
    logic [rmq_pkg::RIGHT_W-1:0] seg_r_reg, seg_r_next;
    logic signed [VW-1:0]   res_reg, res_next;
    logic                   err_reg, err_next;
    logic signed [VW-1:0]   out_val_reg, out_val_next;
    logic                   out_err_reg, out_err_next;

    // stack memory: entries below the top, read one below the next top
    logic                   stk_we;
    logic [LW-1:0]          stk_wptr;
    logic [STK_W-1:0]       stk_wdata, stk_rdata;
    logic [DW-1:0]          stk_dn2;
    logic [LW-1:0]          stk_raddr;

    // memories
    logic                   elem_we, mask_we, tab_we;
    logic [AW-1:0]          elem_waddr, elem_raddr, mask_raddr;
    logic [VW-1:0]          elem_wdata, elem_rdata;
    logic [WORD_SIZE-1:0]   mask_wdata, mask_rdata;
    logic [TAW-1:0]         tab_waddr, tab_raddr;
    logic [VW-1:0]          tab_wdata, tab_rdata;

    // helpers
    logic [DW-1:0]          dm1;
    logic [LW-1:0]          jpos;
    logic [LEN_W-1:0]       len_eff;
    logic [BW:0]            nb;
    logic [BW:0]            nb_rem;
    logic [LX_W-1:0]        lsum;
    logic [BIX_W-1:0]       lb_c, rb_c, blen;
    logic [SW-1:0]          span;
    logic [WORD_SIZE-1:0]   mshift;
    logic                   out_free;
    int                     kc;

    rmq_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    rmq_ram #(.WIDTH(WORD_SIZE), .DEPTH(MAX_ELEMENTS)) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (elem_waddr),
        .wdata (mask_wdata),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    rmq_ram #(.WIDTH(VW), .DEPTH(TDEPTH)) u_tab_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    rmq_ram #(.WIDTH(STK_W), .DEPTH(WORD_SIZE)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_wptr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign empty       = !out_valid_reg;
    assign max_value   = out_val_reg;
    assign range_error = out_err_reg;
    assign out_free    = !out_valid_reg || pop;

    assign dm1    = depth_reg - 1'b1;
    assign jpos   = len_reg[LW-1:0];
    assign nb     = len_reg[LEN_W-1:LW];
    assign nb_rem = nb - bj_reg;
    assign span   = SW'(1) << k_reg;
    assign mshift = mask_rdata >> seg_l_reg[LW-1:0];
    assign blen   = rb_reg - lb_reg;

    assign stk_wptr  = depth_reg[LW-1:0];
    assign stk_wdata = {jpos, val_reg};
    assign stk_dn2   = depth_next - DW'(2);
    assign stk_raddr = stk_dn2[LW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        done_next      = done_reg;
        depth_next     = depth_reg;
        lvl_next       = lvl_reg;
        bj_next        = bj_reg;
        blk_next       = blk_reg;
        sega_next      = sega_reg;
        segb_next      = segb_reg;
        single_next    = single_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !pop;
        rmask_next     = rmask_reg;
        top_idx_next   = top_idx_reg;
        top_val_next   = top_val_reg;
        bot_val_next   = bot_val_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        tmp_next       = tmp_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        lb_next        = lb_reg;
        rb_next        = rb_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        seg_l_next     = seg_l_reg;
        seg_r_next     = seg_r_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        out_val_next   = out_val_reg;
        out_err_next   = out_err_reg;
        take           = 1'b0;
        stk_we         = 1'b0;
        elem_we        = 1'b0;
        mask_we        = 1'b0;
        tab_we         = 1'b0;
        elem_waddr     = len_reg[AW-1:0];
        elem_wdata     = val_reg;
        mask_wdata     = rmask_reg;
        elem_raddr     = AW'(seg_r_reg - 1'b1);
        mask_raddr     = AW'(seg_r_reg - 1'b1);
        tab_waddr      = tab_addr(int'(lvl_reg), int'(bj_reg));
        tab_wdata      = smax(tmp_reg, tab_rdata);
        tab_raddr      = tab_addr(int'(k_reg), int'(pos_reg));
        len_eff        = done_reg ? '0 : len_reg;
        lsum           = LX_W'(head_item.range_left) + LX_W'(WORD_SIZE - 1);
        lb_c           = BIX_W'(lsum >> LW);
        rb_c           = BIX_W'(head_item.range_right >> LW);
        kc             = 0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    take = 1'b1;
                    if (head_item.func == rmq_pkg::FUNC_LOAD)
                    begin
                        done_next = 1'b0;
                        len_next  = len_eff;
                        val_next  = head_item.element_value;
                        last_next = head_item.last_element;
                        if (done_reg || len_eff[LW-1:0] == '0)
                        begin
                            depth_next = '0;
                            rmask_next = '0;
                        end
                        if (!len_eff[AW])
                        begin
                            state_next = S_POP;
                        end
                        else if (head_item.last_element)
                        begin
                            done_next  = 1'b1;
                            lvl_next   = IW'(1);
                            bj_next    = '0;
                            state_next = S_BLD_CHK;
                        end
                    end
                    else if (!done_reg || head_item.bad_order ||
                             LEN_W'(head_item.range_right) > len_reg)
                    begin
                        res_next   = '0;
                        err_next   = 1'b1;
                        state_next = S_Q_NEXT;
                        blk_next   = 1'b0;
                        sega_next  = 1'b0;
                        segb_next  = 1'b0;
                    end
                    else
                    begin
                        l_next      = head_item.range_left;
                        r_next      = head_item.range_right;
                        lb_next     = lb_c;
                        rb_next     = rb_c;
                        single_next = (lb_c > rb_c);
                        blk_next    = (lb_c < rb_c);
                        sega_next   = (lb_c > rb_c) ||
                                      (LX_W'(head_item.range_left) < (LX_W'(lb_c) << LW));
                        segb_next   = (lb_c <= rb_c) &&
                                      ((LX_W'(rb_c) << LW) < LX_W'(head_item.range_right));
                        res_next    = {1'b1, {(VW-1){1'b0}}};
                        err_next    = 1'b0;
                        state_next  = S_Q_NEXT;
                    end
                end
            end

            S_POP:
            begin
                if (depth_reg != '0 && top_val_reg <= val_reg)
                begin
                    rmask_next   = rmask_reg & ~(WORD_SIZE'(1) << top_idx_reg);
                    depth_next   = dm1;
                    top_idx_next = stk_rdata[STK_W-1:VW];
                    top_val_next = stk_rdata[VW-1:0];
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                elem_we      = 1'b1;
                mask_we      = 1'b1;
                stk_we       = 1'b1;
                top_idx_next = jpos;
                top_val_next = val_reg;
                if (depth_reg == '0)
                begin
                    bot_val_next = val_reg;
                end
                rmask_next = rmask_reg | (WORD_SIZE'(1) << jpos);
                depth_next = depth_reg + 1'b1;
                len_next   = len_reg + 1'b1;
                if (jpos == LW'(WORD_SIZE - 1))
                begin
                    tab_we    = 1'b1;
                    tab_waddr = tab_addr(0, int'(nb));
                    tab_wdata = (depth_reg == '0) ? val_reg : bot_val_reg;
                end
                if (last_reg)
                begin
                    done_next  = 1'b1;
                    lvl_next   = IW'(1);
                    bj_next    = '0;
                    state_next = S_BLD_CHK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_BLD_CHK:
            begin
                if (lvl_reg == IW'(BLOCK_LEVELS))
                begin
                    state_next = S_IDLE;
                end
                else if (nb >= bj_reg && (nb_rem >> lvl_reg) != '0)
                begin
                    state_next = S_BLD_RA;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                    bj_next  = '0;
                end
            end

            S_BLD_RA:
            begin
                tab_raddr  = tab_addr(int'(lvl_reg) - 1, int'(bj_reg));
                state_next = S_BLD_RB;
            end

            S_BLD_RB:
            begin
                tab_raddr  = tab_addr(int'(lvl_reg) - 1,
                                      int'(bj_reg) + (1 << (int'(lvl_reg) - 1)));
                tmp_next   = tab_rdata;
                state_next = S_BLD_W;
            end

            S_BLD_W:
            begin
                tab_we     = 1'b1;
                bj_next    = bj_reg + 1'b1;
                state_next = S_BLD_CHK;
            end

            S_Q_NEXT:
            begin
                if (blk_reg)
                begin
                    if (blen != BIX_W'(1))
                    begin
                        kc = flog2(blen - 1'b1);
                        if (kc > BLOCK_LEVELS - 1)
                        begin
                            kc = BLOCK_LEVELS - 1;
                        end
                    end
                    k_next     = KW'(kc);
                    pos_next   = lb_reg;
                    fin_next   = !((SW'(lb_reg) + (SW'(1) << kc)) < SW'(rb_reg));
                    state_next = S_Q_TRD;
                end
                else if (sega_reg)
                begin
                    sega_next  = 1'b0;
                    seg_l_next = l_reg;
                    seg_r_next = single_reg ? r_reg
                                            : rmq_pkg::RIGHT_W'(LX_W'(lb_reg) << LW);
                    state_next = S_W_MRD;
                end
                else if (segb_reg)
                begin
                    segb_next  = 1'b0;
                    seg_l_next = rmq_pkg::LEFT_W'(LX_W'(rb_reg) << LW);
                    seg_r_next = r_reg;
                    state_next = S_W_MRD;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end

            S_Q_TRD:
            begin
                if (fin_reg)
                begin
                    tab_raddr = tab_addr(int'(k_reg), int'(SW'(rb_reg) - span));
                end
                state_next = S_Q_TWT;
            end

            S_Q_TWT:
            begin
                res_next = smax(res_reg, tab_rdata);
                if (fin_reg)
                begin
                    blk_next   = 1'b0;
                    state_next = S_Q_NEXT;
                end
                else
                begin
                    pos_next   = BIX_W'(SW'(pos_reg) + span);
                    fin_next   = !((SW'(pos_reg) + span + span) < SW'(rb_reg));
                    state_next = S_Q_TRD;
                end
            end

            S_W_MRD:
            begin
                state_next = S_W_MWT;
            end

            S_W_MWT:
            begin
                // empty mask: the last position of the segment is the maximum
                if (mshift != '0)
                begin
                    elem_raddr = AW'(seg_l_reg + rmq_pkg::LEFT_W'(ctz(mshift)));
                    state_next = S_W_EWT;
                end
                else
                begin
                    res_next   = smax(res_reg, elem_rdata);
                    state_next = S_Q_NEXT;
                end
            end

            S_W_EWT:
            begin
                res_next   = smax(res_reg, elem_rdata);
                state_next = S_Q_NEXT;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            done_reg      <= 1'b0;
            depth_reg     <= '0;
            lvl_reg       <= '0;
            bj_reg        <= '0;
            blk_reg       <= 1'b0;
            sega_reg      <= 1'b0;
            segb_reg      <= 1'b0;
            single_reg    <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            rmask_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            done_reg      <= done_next;
            depth_reg     <= depth_next;
            lvl_reg       <= lvl_next;
            bj_reg        <= bj_next;
            blk_reg       <= blk_next;
            sega_reg      <= sega_next;
            segb_reg      <= segb_next;
            single_reg    <= single_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            rmask_reg     <= rmask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_idx_reg <= top_idx_next;
        top_val_reg <= top_val_next;
        bot_val_reg <= bot_val_next;
        val_reg     <= val_next;
        last_reg    <= last_next;
        tmp_reg     <= tmp_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        lb_reg      <= lb_next;
        rb_reg      <= rb_next;
        k_reg       <= k_next;
        pos_reg     <= pos_next;
        seg_l_reg   <= seg_l_next;
        seg_r_reg   <= seg_r_next;
        res_reg     <= res_next;
        err_reg     <= err_next;
        out_val_reg <= out_val_next;
        out_err_reg <= out_err_next;
    end

endmodule

FILE: hw/rtl/range_max_query_engine.sv
// ----------------------------------------------------------------------------
// range_max_query_engine
// Range maximum over a loaded array of signed 64-bit values, with per-word
// monotonic-stack masks and a sparse table of word maxima.
// ----------------------------------------------------------------------------
// channel  direction  handshake      payload
// input    in         push / full    func, element_value, last_element,
//                                    range_left, range_right
// result   out        pop / empty    max_value, range_error
//
// Load: each element pops dominated stack entries one at a time, then is pushed.
// Last element: the build reads two table entries and writes one per entry,
// table RAM port bound. Query: sparse-table reads for whole words, a mask read
// and an element read per partial word; rejected queries skip them. One item
// executes at a time; a two-entry input queue and the result register keep both
// sides stalling on their own. Reset clears control only; no clearing pass.
// ----------------------------------------------------------------------------
module range_max_query_engine #(
    parameter int MAX_ELEMENTS = rmq_pkg::MAX_ELEMENTS_DEF,
    parameter int WORD_SIZE    = rmq_pkg::WORD_SIZE_DEF,
    parameter int BLOCK_LEVELS = rmq_pkg::BLOCK_LEVELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               func,
    input  logic signed [rmq_pkg::VALUE_W-1:0] element_value,
    input  logic                               last_element,
    input  logic [rmq_pkg::LEFT_W-1:0]         range_left,
    input  logic [rmq_pkg::RIGHT_W-1:0]        range_right,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [rmq_pkg::VALUE_W-1:0] max_value,
    output logic                               range_error
);

    logic           head_valid;
    rmq_pkg::item_t head_item;
    logic           take;

    rmq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .func          (rmq_pkg::func_t'(func)),
        .element_value (element_value),
        .last_element  (last_element),
        .range_left    (range_left),
        .range_right   (range_right),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .take          (take)
    );

    rmq_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .WORD_SIZE    (WORD_SIZE),
        .BLOCK_LEVELS (BLOCK_LEVELS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .take        (take),
        .empty       (empty),
        .pop         (pop),
        .max_value   (max_value),
        .range_error (range_error)
    );

endmodule

FILE: tb/sv/range_max_query_engine_tb.sv
// ----------------------------------------------------------------------------
// range_max_query_engine_tb
// Loads arrays of signed 64-bit values and checks every range maximum query
// against a scan of the testbench's own copy of the loaded array. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module range_max_query_engine_tb;

    localparam int CAPACITY    = 4096;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        rmq_pkg::func_t             func;
        logic [63:0]                value;
        logic                       last;
        logic [rmq_pkg::LEFT_W-1:0]  left;
        logic [rmq_pkg::RIGHT_W-1:0] right;
        bit                         hold;
    } stim_t;

    typedef struct {
        logic signed [63:0] value;
        logic               err;
    } answer_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic func;
    logic signed [rmq_pkg::VALUE_W-1:0] element_value;
    logic last_element;
    logic [rmq_pkg::LEFT_W-1:0] range_left;
    logic [rmq_pkg::RIGHT_W-1:0] range_right;
    logic empty;
    logic pop;
    logic signed [rmq_pkg::VALUE_W-1:0] max_value;
    logic range_error;

    range_max_query_engine u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .element_value(element_value), .last_element(last_element),
        .range_left(range_left), .range_right(range_right), .empty(empty),
        .pop(pop), .max_value(max_value), .range_error(range_error)
    );

    stim_t   pending[$];
    answer_t answers[$];

    logic signed [63:0] array_copy [CAPACITY];
    int  array_len;
    bit  array_done;

    stim_t cur;
    bit    have;
    bit    took;
    bit    popped;
    int    send_gap;
    int    recv_gap;
    bit    send_burst;
    bit    recv_burst;
    int    cycles;
    int    failures;
    int    n_loads;
    int    n_queries;
    int    n_errors;
    int    n_checked;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Expected answer for one accepted item
    task automatic apply_item(input stim_t it);
        answer_t a;
        int l;
        int r;
        if (it.func == rmq_pkg::FUNC_LOAD)
        begin
            n_loads++;
            if (array_done)
            begin
                array_done = 0;
                array_len = 0;
            end
            if (array_len < CAPACITY)
            begin
                array_copy[array_len] = it.value;
                array_len++;
            end
            if (it.last)
                array_done = 1;
        end
        else
        begin
            n_queries++;
            l = int'(it.left);
            r = int'(it.right);
            a.value = '0;
            a.err = 1'b0;
            if (!array_done || l >= r || r > array_len)
            begin
                a.err = 1'b1;
                n_errors++;
            end
            else
            begin
                a.value = array_copy[l];
                for (int i = l + 1; i < r; i++)
                    if (array_copy[i] > a.value)
                        a.value = array_copy[i];
            end
            answers.push_back(a);
        end
    endtask

    always @(posedge clk)
    begin
        answer_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        if (rst_n && pop && !empty)
        begin
            popped = 1;
            n_checked++;
            if (answers.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result max_value=%0d range_error=%0b",
                         $time, max_value, range_error);
            end
            else
            begin
                e = answers.pop_front();
                if (max_value !== e.value)
                begin
                    failures++;
                    $display("%0t: max_value expected %0d actual %0d",
                             $time, e.value, max_value);
                end
                if (range_error !== e.err)
                begin
                    failures++;
                    $display("%0t: range_error expected %0b actual %0b",
                             $time, e.err, range_error);
                end
            end
        end
        if (rst_n && push && !full)
        begin
            took = 1;
            apply_item(cur);
        end
    end

    // Sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took)
            begin
                took = 0;
                have = 0;
                if ($urandom_range(0, 15) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 16);
            end
            if (!have)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending.size() > 0 &&
                         (!pending[0].hold || answers.size() == 0))
                begin
                    cur = pending.pop_front();
                    have = 1;
                end
            end
            push <= have;
            func <= cur.func;
            element_value <= cur.value;
            last_element <= cur.last;
            range_left <= cur.left;
            range_right <= cur.right;
        end
    end

    // Receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (popped)
            begin
                popped = 0;
                if ($urandom_range(0, 15) == 0)
                    recv_burst = !recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 16);
            end
            if (recv_gap > 0)
                recv_gap--;
            pop <= (recv_gap == 0);
        end
    end

    task automatic add_load(input logic [63:0] v, input bit last_one);
        stim_t s;
        s.func = rmq_pkg::FUNC_LOAD;
        s.value = v;
        s.last = last_one;
        s.left = rmq_pkg::LEFT_W'($urandom);
        s.right = rmq_pkg::RIGHT_W'($urandom);
        s.hold = 0;
        pending.push_back(s);
    endtask

    task automatic add_query(input int l, input int r, input bit hold);
        stim_t s;
        s.func = rmq_pkg::FUNC_QUERY;
        s.value = {$urandom, $urandom};
        s.last = 1'($urandom_range(0, 1));
        s.left = rmq_pkg::LEFT_W'(l);
        s.right = rmq_pkg::RIGHT_W'(r);
        s.hold = hold;
        pending.push_back(s);
    endtask

    task automatic add_queries(input int len, input int count);
        int l;
        int span;
        int room;
        for (int q = 0; q < count; q++)
        begin
            if ($urandom_range(0, 99) < 15)
                add_query($urandom_range(0, 4095), $urandom_range(0, 4096), 0);
            else
            begin
                l = $urandom_range(0, len - 1);
                room = len - l - 1;
                case ($urandom_range(0, 2))
                    0: span = (room < 64) ? room : 64;
                    1: span = (room < 300) ? room : 300;
                    default: span = room;
                endcase
                add_query(l, l + 1 + $urandom_range(0, span), 0);
            end
        end
    endtask

    function automatic logic [63:0] draw_value(input int mode, input int idx, input int len);
        case (mode)
            0: return {$urandom, $urandom};
            1: return 64'($signed($urandom_range(0, 6)) - 3);
            2: return 64'(idx * 1000 + $urandom_range(0, 999)) - 64'd2000000;
            default: return 64'((len - idx) * 1000 + $urandom_range(0, 999));
        endcase
    endfunction

    initial
    begin
        int len;
        int mode;
        int nq;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        func = rmq_pkg::FUNC_LOAD;
        element_value = '0;
        last_element = 1'b0;
        range_left = '0;
        range_right = '0;
        cur = '{rmq_pkg::FUNC_LOAD, '0, 1'b0, '0, '0, 1'b0};
        have = 0;
        took = 0;
        popped = 0;
        send_gap = 0;
        recv_gap = 0;
        send_burst = 0;
        recv_burst = 0;
        cycles = 0;
        failures = 0;
        array_len = 0;
        array_done = 0;

        // directed part
        add_query(0, 1, 0);
        add_load(64'h8000_0000_0000_0000, 0);
        add_load(64'h7FFF_FFFF_FFFF_FFFF, 0);
        add_load(64'h0, 0);
        add_load(64'hFFFF_FFFF_FFFF_FFFF, 0);
        add_load(64'h7FFF_FFFF_FFFF_FFFF, 0);
        add_load(64'h5, 1);
        add_query(0, 6, 1);
        add_query(0, 1, 0);
        add_query(5, 6, 0);
        add_query(2, 4, 0);
        add_query(3, 3, 0);
        add_query(4, 2, 0);
        add_query(0, 7, 0);
        add_query(4095, 4096, 0);
        add_load(64'hFFFF_FFFF_FFFF_FFF0, 1);
        add_query(0, 1, 0);
        add_query(0, 2, 0);

        while (pending.size() < 1200)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 450)
                                              : $urandom_range(1, 120);
            mode = $urandom_range(0, 3);
            for (int i = 0; i < len; i++)
            begin
                if (i == len / 2 && $urandom_range(0, 3) == 0)
                    add_query(0, 1, 0);
                add_load(draw_value(mode, i, len), i == len - 1);
            end
            nq = $urandom_range(10, 40);
            add_query(0, len, $urandom_range(0, 3) == 0);
            add_queries(len, nq);
        end

        wait (pending.size() == 0);
        do
            @(posedge clk);
        while (have || answers.size() != 0);
        repeat (100) @(posedge clk);
        $display("Covered %0d loads and %0d queries (%0d rejected), %0d results checked.",
                 n_loads, n_queries, n_errors, n_checked);
        if (failures == 0 && answers.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end
endmodule

FILE: range_max_query_engine.f
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_ram.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_back.sv
hw/rtl/range_max_query_engine.sv
tb/sv/range_max_query_engine_tb.sv
